>>> hw/rtl/ssp_pkg.sv
package ssp_pkg;

	// default graph size
	localparam int MAX_VERTICES = 32;

	// fixed field widths
	localparam int DIST_W   = 24;
	localparam int WEIGHT_W = 16;
	localparam int FIELD_W  = 5;
	localparam int CFG_W    = 6;

	// saturated distance, means unreachable
	localparam logic [DIST_W-1:0] DIST_INF = '1;

	// operation codes
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	// controller states
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_PASS  = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic init;
		logic shift;
	} cell_ctl_t;

endpackage

>>> hw/rtl/ssp_edge_mem.sv
module ssp_edge_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/ssp_cell.sv
module ssp_cell #(
	parameter int IDX = 0,
	parameter int VW  = 5,
	parameter int NW  = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ssp_pkg::cell_ctl_t         ctl,
	input  logic [NW-1:0]              n,
	input  logic [VW-1:0]              src,
	input  logic [VW-1:0]              u,
	input  logic [ssp_pkg::DIST_W-1:0] du,
	input  logic                       edge_present,
	input  logic [ssp_pkg::WEIGHT_W-1:0] edge_w,
	input  logic                       tok_i,
	input  logic [ssp_pkg::DIST_W-1:0] best_i,
	input  logic [VW-1:0]              pick_i,
	input  logic [ssp_pkg::DIST_W-1:0] d_right,
	output logic                       tok_o,
	output logic [ssp_pkg::DIST_W-1:0] best_o,
	output logic [VW-1:0]              pick_o,
	output logic [ssp_pkg::DIST_W-1:0] d_o
);

	logic                       tok_q;
	logic [ssp_pkg::DIST_W-1:0] best_q;
	logic [VW-1:0]              pick_q;
	logic [ssp_pkg::DIST_W-1:0] d_q;
	logic                       settled_q;

	logic                       active;
	logic                       here;
	logic                       is_u;
	logic [ssp_pkg::DIST_W:0]   sum;
	logic [ssp_pkg::DIST_W-1:0] sat;
	logic                       relax;
	logic [ssp_pkg::DIST_W-1:0] d_new;
	logic                       cand;

	assign active = (int'(n) > IDX);
	assign here   = tok_i && active;
	assign is_u   = (u == VW'(IDX));

	// relax this vertex against the settled one, saturating
	assign sum   = {1'b0, du} + {{(ssp_pkg::DIST_W + 1 - ssp_pkg::WEIGHT_W){1'b0}}, edge_w};
	assign sat   = sum[ssp_pkg::DIST_W] ? ssp_pkg::DIST_INF : sum[ssp_pkg::DIST_W-1:0];
	assign relax = here && edge_present && (sat < d_q);
	assign d_new = relax ? sat : d_q;

	// running minimum; ties go to the higher index
	assign cand = here && !settled_q && !is_u && (d_new <= best_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_i;
		end
	end

	always_ff @(posedge clk) begin
		best_q <= cand ? d_new : best_i;
		pick_q <= cand ? VW'(IDX) : pick_i;
		if (ctl.init) begin
			d_q       <= (src == VW'(IDX)) ? '0 : ssp_pkg::DIST_INF;
			settled_q <= 1'b0;
		end else if (ctl.shift) begin
			d_q <= d_right;
		end else if (here) begin
			d_q <= d_new;
			if (is_u) begin
				settled_q <= 1'b1;
			end
		end
	end

	assign tok_o  = tok_q;
	assign best_o = best_q;
	assign pick_o = pick_q;
	assign d_o    = d_q;

endmodule

>>> hw/rtl/single_source_shortest_paths.sv
// Add edge: accepted while idle, no result.
// Run: n passes, each one token sweep over the cell row fed by one edge-memory
// read per cycle, then n result beats at one per cycle unless out_stall holds them.
// Reset and every vertex_count write start a clearing sweep of all MAX_V*MAX_V entries
// of the edge memory; input is stalled during it. vertex_count resets to min(MAX_V, 32).
module single_source_shortest_paths #(
	parameter int MAX_V = ssp_pkg::MAX_VERTICES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [ssp_pkg::FIELD_W-1:0]    from_vertex,
	input  logic [ssp_pkg::FIELD_W-1:0]    to_vertex,
	input  logic [ssp_pkg::WEIGHT_W-1:0]   edge_weight,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ssp_pkg::FIELD_W-1:0]    vertex_index,
	output logic [ssp_pkg::DIST_W-1:0]     path_distance,
	output logic                           reachable,
	output logic                           last_result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ssp_pkg::CFG_W-1:0]      cfg_data
);

	localparam int VW    = $clog2(MAX_V);
	localparam int NW    = $clog2(MAX_V + 1);
	localparam int DEPTH = MAX_V * MAX_V;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = ssp_pkg::DIST_W;

	ssp_pkg::state_t    state_q;
	logic [NW-1:0]      n_q;
	logic [AW-1:0]      clr_q;
	logic [VW-1:0]      ctr_q;
	logic [VW-1:0]      round_q;
	logic               launch_q;
	logic [VW-1:0]      u_q;
	logic [DW-1:0]      du_q;
	logic [NW-1:0]      out_cnt_q;
	logic               out_valid_q;
	logic [ssp_pkg::FIELD_W-1:0] vertex_index_q;
	logic [DW-1:0]      path_distance_q;
	logic               reachable_q;
	logic               last_result_q;

	logic               in_acc;
	logic               from_ok;
	logic               to_ok;
	logic               run_go;
	logic               out_load;
	logic [NW-1:0]      cfg_n;
	logic [VW-1:0]      from_v;
	logic [VW-1:0]      to_v;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ssp_pkg::WEIGHT_W:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [ssp_pkg::WEIGHT_W:0] mem_rdata;

	ssp_pkg::cell_ctl_t ctl;
	logic               tok      [MAX_V+1];
	logic [DW-1:0]      best     [MAX_V+1];
	logic [VW-1:0]      pick     [MAX_V+1];
	logic [DW-1:0]      row_dist [MAX_V];

	// input handshake and range checks
	assign in_stall = (state_q != ssp_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign from_ok  = int'(from_vertex) < int'(n_q);
	assign to_ok    = int'(to_vertex) < int'(n_q);
	assign from_v   = VW'(from_vertex);
	assign to_v     = VW'(to_vertex);
	assign run_go   = in_acc && (operation == ssp_pkg::OP_RUN) && from_ok;

	// vertex_count clamp
	always_comb begin
		if (int'(cfg_data) < 2) begin
			cfg_n = NW'(2);
		end else if (int'(cfg_data) > MAX_V) begin
			cfg_n = NW'(MAX_V);
		end else begin
			cfg_n = NW'(cfg_data);
		end
	end

	assign cfg_ready = 1'b1;

	// edge memory: clearing sweep or edge write, read row u_q
	assign mem_we    = (state_q == ssp_pkg::ST_CLEAR) ||
	                   (in_acc && (operation == ssp_pkg::OP_ADD) && from_ok && to_ok);
	assign mem_waddr = (state_q == ssp_pkg::ST_CLEAR) ? clr_q :
	                   AW'(from_v) * AW'(MAX_V) + AW'(to_v);
	assign mem_wdata = (state_q == ssp_pkg::ST_CLEAR) ? '0 : {1'b1, edge_weight};
	assign mem_raddr = AW'(u_q) * AW'(MAX_V) + AW'(ctr_q);

	ssp_edge_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (ssp_pkg::WEIGHT_W + 1)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result stage load
	assign out_load = (state_q == ssp_pkg::ST_OUT) && (!out_valid_q || !out_stall);

	assign ctl.init  = run_go;
	assign ctl.shift = out_load;

	// row of vertex cells, token enters at cell 0
	assign tok[0]  = launch_q;
	assign best[0] = ssp_pkg::DIST_INF;
	assign pick[0] = '0;

	for (genvar i = 0; i < MAX_V; i++) begin : g_cell
		logic [DW-1:0] d_right;
		if (i == MAX_V - 1) begin : g_end
			assign d_right = ssp_pkg::DIST_INF;
		end else begin : g_mid
			assign d_right = row_dist[i+1];
		end
		ssp_cell #(
			.IDX (i),
			.VW  (VW),
			.NW  (NW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.n            (n_q),
			.src          (from_v),
			.u            (u_q),
			.du           (du_q),
			.edge_present (mem_rdata[ssp_pkg::WEIGHT_W]),
			.edge_w       (mem_rdata[ssp_pkg::WEIGHT_W-1:0]),
			.tok_i        (tok[i]),
			.best_i       (best[i]),
			.pick_i       (pick[i]),
			.d_right      (d_right),
			.tok_o        (tok[i+1]),
			.best_o       (best[i+1]),
			.pick_o       (pick[i+1]),
			.d_o          (row_dist[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ssp_pkg::ST_CLEAR;
			n_q       <= NW'(MAX_V < 32 ? MAX_V : 32);
			clr_q     <= '0;
			ctr_q     <= '0;
			round_q   <= '0;
			launch_q  <= 1'b0;
			out_cnt_q <= '0;
		end else begin
			launch_q <= (state_q == ssp_pkg::ST_PASS) && (ctr_q == '0);
			if (cfg_valid) begin
				n_q     <= cfg_n;
				clr_q   <= '0;
				state_q <= ssp_pkg::ST_CLEAR;
			end else begin
				unique case (state_q)
					ssp_pkg::ST_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == AW'(DEPTH - 1)) begin
							state_q <= ssp_pkg::ST_IDLE;
						end
					end
					ssp_pkg::ST_IDLE: begin
						if (run_go) begin
							round_q <= '0;
							ctr_q   <= '0;
							state_q <= ssp_pkg::ST_PASS;
						end
					end
					ssp_pkg::ST_PASS: begin
						ctr_q <= ctr_q + 1'b1;
						if (ctr_q == VW'(MAX_V - 1)) begin
							state_q <= ssp_pkg::ST_WAIT;
						end
					end
					ssp_pkg::ST_WAIT: begin
						if (tok[MAX_V]) begin
							if (int'(round_q) == int'(n_q) - 1) begin
								out_cnt_q <= '0;
								state_q   <= ssp_pkg::ST_OUT;
							end else begin
								round_q <= round_q + 1'b1;
								ctr_q   <= '0;
								state_q <= ssp_pkg::ST_PASS;
							end
						end
					end
					ssp_pkg::ST_OUT: begin
						if (out_load) begin
							out_cnt_q <= out_cnt_q + 1'b1;
							if (out_cnt_q == n_q - 1'b1) begin
								state_q <= ssp_pkg::ST_IDLE;
							end
						end
					end
					default: begin
						state_q <= ssp_pkg::ST_IDLE;
					end
				endcase
			end
		end
	end

	// settled vertex and its distance for the next pass
	always_ff @(posedge clk) begin
		if (run_go) begin
			u_q  <= from_v;
			du_q <= '0;
		end else if ((state_q == ssp_pkg::ST_WAIT) && tok[MAX_V]) begin
			u_q  <= pick[MAX_V];
			du_q <= best[MAX_V];
		end
	end

	// result register, fed from cell 0 as the row shifts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			vertex_index_q  <= ssp_pkg::FIELD_W'(out_cnt_q);
			path_distance_q <= row_dist[0];
			reachable_q     <= (row_dist[0] != ssp_pkg::DIST_INF);
			last_result_q   <= (out_cnt_q == n_q - 1'b1);
		end
	end

	assign out_valid     = out_valid_q;
	assign vertex_index  = vertex_index_q;
	assign path_distance = path_distance_q;
	assign reachable     = reachable_q;
	assign last_result   = last_result_q;

`ifndef ASSERT_OFF
	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(n_q) >= 2) && (int'(n_q) <= MAX_V))
		else $error("vertex count out of range");

	a_launch_pass: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> (state_q == ssp_pkg::ST_PASS) || $past(cfg_valid))
		else $error("token launched outside a pass");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ssp_pkg::ST_OUT))
		else $error("result beat outside output phase");
`endif

endmodule
